// ===== hw/rtl/fa_pkg.sv =====
// ----------------------------------------------------------------------------
// fa_pkg
// Shared types and constants of the frame allocator: field widths, operation
// and status codes, register map and the control group of the recency chain.
// ----------------------------------------------------------------------------
package fa_pkg;

    localparam int unsigned NUM_FRAMES = 64;
    localparam int unsigned CFG_W    = 7;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned IDX_W    = 6;
    localparam int unsigned PAGE_W   = 20;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned PADDR_W  = 3;
    localparam int unsigned PDATA_W  = 32;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 7'd64;

    // register index, taken from paddr[2]
    localparam logic REG_FRAMES_IN_USE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_TOUCH = 2'd2,
        OP_QUERY = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_IS_FREE = 2'd2
    } t_status;

    typedef struct packed {
        logic clear;   // empty the whole order
        logic append;  // load fill into the first empty cell
        logic remove;  // close the gap at the matching cell
        logic head;    // match the head instead of the key
        logic refill;  // after a remove, load fill into the last used cell
    } t_chain_ctl;

endpackage

// ===== hw/rtl/fa_if.sv =====
// ----------------------------------------------------------------------------
// fa_in_if / fa_out_if
// Valid/ready channels of the frame allocator: request items in, result
// items out.
// ----------------------------------------------------------------------------
interface fa_in_if;
    import fa_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [IDX_W-1:0]    frame_index;
    logic [PAGE_W-1:0]   page_number;

    modport source (output valid, output op, output frame_index, output page_number,
                    input ready);
    modport sink   (input valid, input op, input frame_index, input page_number,
                    output ready);
endinterface

interface fa_out_if;
    import fa_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    assigned_frame;
    logic [PAGE_W-1:0]   page_out;
    logic                evicted;
    logic                frame_free;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output assigned_frame, output page_out, output evicted,
                    output frame_free, output status, input ready);
    modport sink   (input valid, input assigned_frame, input page_out, input evicted,
                    input frame_free, input status, output ready);
endinterface

// ===== hw/rtl/fa_cell.sv =====
// ----------------------------------------------------------------------------
// fa_cell
// One slot of the recency order: a frame number and a valid flag. Takes the
// value of its right neighbor when a removal lies at or left of it.
// ----------------------------------------------------------------------------
module fa_cell #(
    parameter int unsigned FRAME_W = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fa_pkg::t_chain_ctl i_ctl,
    input  logic [FRAME_W-1:0] i_key,
    input  logic [FRAME_W-1:0] i_fill,
    input  logic               i_prev_valid,
    input  logic               i_shift_in,
    input  logic               i_next_valid,
    input  logic [FRAME_W-1:0] i_next_val,
    output logic               o_shift_out,
    output logic               o_valid,
    output logic [FRAME_W-1:0] o_val
);
    import fa_pkg::*;

    logic               r_valid;
    logic [FRAME_W-1:0] r_val;
    logic               n_valid;
    logic [FRAME_W-1:0] n_val;
    logic               w_hit;

    assign w_hit       = i_ctl.remove && !i_ctl.head && r_valid && (r_val == i_key);
    assign o_shift_out = i_shift_in || w_hit;
    assign o_valid     = r_valid;
    assign o_val       = r_val;

    always_comb begin
        n_valid = r_valid;
        n_val   = r_val;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.append && !r_valid && i_prev_valid) begin
            n_valid = 1'b1;
            n_val   = i_fill;
        end else if (o_shift_out && r_valid) begin
            if (i_next_valid) begin
                n_val = i_next_val;
            end else if (i_ctl.refill) begin
                n_val = i_fill;
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

// ===== hw/rtl/fa_lru_chain.sv =====
// ----------------------------------------------------------------------------
// fa_lru_chain
// Row of recency cells, oldest frame in cell 0. Used cells always form a
// prefix of the row.
// ----------------------------------------------------------------------------
module fa_lru_chain #(
    parameter int unsigned NUM_FRAMES = 64,
    parameter int unsigned FRAME_W    = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fa_pkg::t_chain_ctl    i_ctl,
    input  logic [FRAME_W-1:0]    i_key,
    input  logic [FRAME_W-1:0]    i_fill,
    output logic [FRAME_W-1:0]    o_head,
    output logic [NUM_FRAMES-1:0] o_valid
);
    import fa_pkg::*;

    logic [FRAME_W-1:0]    w_val   [NUM_FRAMES];
    logic [NUM_FRAMES-1:0] w_shift;

    assign o_head = w_val[0];

    for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
        logic               w_prev_valid;
        logic               w_shift_in;
        logic               w_next_valid;
        logic [FRAME_W-1:0] w_next_val;

        if (g == 0) begin : g_first
            assign w_prev_valid = 1'b1;
            assign w_shift_in   = i_ctl.remove && i_ctl.head;
        end else begin : g_mid
            assign w_prev_valid = o_valid[g-1];
            assign w_shift_in   = w_shift[g-1];
        end

        if (g == NUM_FRAMES - 1) begin : g_last
            assign w_next_valid = 1'b0;
            assign w_next_val   = '0;
        end else begin : g_inner
            assign w_next_valid = o_valid[g+1];
            assign w_next_val   = w_val[g+1];
        end

        fa_cell #(
            .FRAME_W (FRAME_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_key        (i_key),
            .i_fill       (i_fill),
            .i_prev_valid (w_prev_valid),
            .i_shift_in   (w_shift_in),
            .i_next_valid (w_next_valid),
            .i_next_val   (w_next_val),
            .o_shift_out  (w_shift[g]),
            .o_valid      (o_valid[g]),
            .o_val        (w_val[g])
        );
    end

endmodule

// ===== hw/rtl/frame_allocator_lru_evict.sv =====
// ----------------------------------------------------------------------------
// frame_allocator_lru_evict
// Physical frame manager with least-recently-used eviction.
//
// Requests arrive on i_in (op, frame_index, page_number); one result item per
// request leaves on o_out in the cycle after acceptance, held in an output
// register. An item is accepted every cycle while the output register is
// empty or being taken, so throughput is one item per cycle. The whole update
// is done in the cycle of acceptance: a priority encoder over the free bitmap
// picks the lowest free frame, and the recency order lives in a row of
// NUM_FRAMES cells that shift toward the head to close a gap and load the
// tail in the same cycle.
// When the receiver stalls, the result holds and i_in.ready drops until it
// is taken.
// Reset, and every write of frames_in_use (address 0 of the APB port), frees
// all frames and empties the order; its low CFG_W bits read back as written
// and the upper bits read as zero. Write it only while no item is in flight.
// ----------------------------------------------------------------------------
module frame_allocator_lru_evict (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fa_pkg::PADDR_W-1:0]   paddr,
    input  logic [fa_pkg::PDATA_W-1:0]   pwdata,
    output logic [fa_pkg::PDATA_W-1:0]   prdata,
    output logic                         pready,
    fa_in_if.sink                        i_in,
    fa_out_if.source                     o_out
);
    import fa_pkg::*;

    localparam int unsigned FRAME_W = $clog2(NUM_FRAMES);
    localparam int unsigned MAX_EFF = (NUM_FRAMES < 127) ? NUM_FRAMES : 127;
    localparam logic [CFG_W-1:0] MAX_EFF_W = CFG_W'(MAX_EFF);
    localparam logic [CFG_W-1:0] RST_EFF   =
        (FRAMES_RESET > MAX_EFF_W) ? MAX_EFF_W : FRAMES_RESET;

    logic [CFG_W-1:0]      r_cfg;
    logic [CFG_W-1:0]      r_eff;
    logic [CFG_W-1:0]      r_free_count;
    logic [NUM_FRAMES-1:0] r_free_map;

    logic [CFG_W-1:0]      n_free_count;
    logic [NUM_FRAMES-1:0] n_free_map;

    logic                  r_o_valid;
    logic [IDX_W-1:0]      r_o_frame;
    logic [PAGE_W-1:0]     r_o_page;
    logic                  r_o_evicted;
    logic                  r_o_free;
    t_status               r_o_status;

    logic [IDX_W-1:0]      n_o_frame;
    logic                  n_o_evicted;
    logic                  n_o_free;
    t_status               n_o_status;

    logic                  w_cfg_wr;
    logic [CFG_W-1:0]      w_new_cfg;
    logic [CFG_W-1:0]      w_new_eff;
    logic                  w_in_fire;
    logic [FRAME_W-1:0]    w_alloc;
    logic [FRAME_W-1:0]    w_idx;
    logic                  w_idx_free;
    logic                  w_range_err;
    logic [FRAME_W-1:0]    w_head;
    logic [NUM_FRAMES-1:0] w_vld;
    t_chain_ctl            w_ctl;
    logic [FRAME_W-1:0]    w_fill;

    // configuration port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready && (paddr[2] == REG_FRAMES_IN_USE);
    assign w_new_cfg = pwdata[CFG_W-1:0];
    assign w_new_eff = (w_new_cfg == '0) ? CFG_W'(1) :
                       (w_new_cfg > MAX_EFF_W) ? MAX_EFF_W : w_new_cfg;
    assign prdata    = (paddr[2] == REG_FRAMES_IN_USE) ? PDATA_W'(r_cfg) : '0;

    // handshake
    assign i_in.ready = !r_o_valid || o_out.ready;
    assign w_in_fire  = i_in.valid && i_in.ready;

    assign w_idx       = FRAME_W'(i_in.frame_index);
    assign w_range_err = ({1'b0, i_in.frame_index} >= r_eff);
    assign w_idx_free  = r_free_map[w_idx];

    // lowest free frame among the managed ones
    always_comb begin
        w_alloc = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (r_free_map[i] && (i < int'(r_eff))) begin
                w_alloc = FRAME_W'(i);
            end
        end
    end

    always_comb begin
        n_free_map   = r_free_map;
        n_free_count = r_free_count;
        n_o_frame    = i_in.frame_index;
        n_o_evicted  = 1'b0;
        n_o_free     = 1'b0;
        n_o_status   = ST_OK;
        w_ctl        = '0;
        w_fill       = w_idx;
        w_ctl.clear  = w_cfg_wr;
        case (t_op'(i_in.op))
            OP_ALLOC: begin
                if (r_free_count != '0) begin
                    n_free_map[w_alloc] = 1'b0;
                    n_free_count        = r_free_count - 1'b1;
                    n_o_frame           = IDX_W'(w_alloc);
                    w_ctl.append        = w_in_fire;
                    w_fill              = w_alloc;
                end else if (w_vld[0]) begin
                    n_o_frame    = IDX_W'(w_head);
                    n_o_evicted  = 1'b1;
                    w_ctl.remove = w_in_fire;
                    w_ctl.head   = 1'b1;
                    w_ctl.refill = 1'b1;
                    w_fill       = w_head;
                end else begin
                    n_o_frame  = '0;
                    n_o_status = ST_RANGE;
                end
            end
            OP_QUERY: begin
                if (w_range_err) begin
                    n_o_status = ST_RANGE;
                end else begin
                    n_o_free = w_idx_free;
                end
            end
            OP_FREE, OP_TOUCH: begin
                if (w_range_err) begin
                    n_o_status = ST_RANGE;
                end else if (w_idx_free) begin
                    n_o_status = ST_IS_FREE;
                end else begin
                    w_ctl.remove = w_in_fire;
                    w_ctl.refill = (t_op'(i_in.op) == OP_TOUCH);
                    if (t_op'(i_in.op) == OP_FREE) begin
                        n_free_map[w_idx] = 1'b1;
                        n_free_count      = r_free_count + 1'b1;
                    end
                end
            end
            default: begin
                n_o_status = ST_OK;
            end
        endcase
    end

    fa_lru_chain #(
        .NUM_FRAMES (NUM_FRAMES),
        .FRAME_W    (FRAME_W)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_key   (w_idx),
        .i_fill  (w_fill),
        .o_head  (w_head),
        .o_valid (w_vld)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= FRAMES_RESET;
            r_eff        <= RST_EFF;
            r_free_count <= RST_EFF;
            r_free_map   <= '1;
            r_o_valid    <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                r_cfg        <= w_new_cfg;
                r_eff        <= w_new_eff;
                r_free_count <= w_new_eff;
                r_free_map   <= '1;
            end else if (w_in_fire) begin
                r_free_count <= n_free_count;
                r_free_map   <= n_free_map;
            end
            if (w_in_fire) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_o_frame   <= n_o_frame;
            r_o_page    <= i_in.page_number;
            r_o_evicted <= n_o_evicted;
            r_o_free    <= n_o_free;
            r_o_status  <= n_o_status;
        end
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.assigned_frame = r_o_frame;
    assign o_out.page_out       = r_o_page;
    assign o_out.evicted        = r_o_evicted;
    assign o_out.frame_free     = r_o_free;
    assign o_out.status         = r_o_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_count <= r_eff)
        else $error("free count above managed frame count");

    a_order_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_vld + 1'b1) & w_vld) == '0)
        else $error("recency order has a hole");

    a_order_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($countones(w_vld) + int'(r_free_count)) == int'(r_eff))
        else $error("order length and free count disagree");

    a_evict_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_fire && w_ctl.head |-> r_free_count == '0)
        else $error("eviction while a frame is free");

endmodule

// ===== tb/fa_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fa_result_checker
// Watches the request and result channels and the register port of the frame
// allocator. Keeps its own free bitmap and recency order, works out the
// result of every accepted request and compares each result item field by
// field with the oldest expected one.
// ----------------------------------------------------------------------------
module fa_result_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic [fa_pkg::PADDR_W-1:0] i_paddr,
    input  logic [fa_pkg::PDATA_W-1:0] i_pwdata,
    input  logic                       i_pready,
    fa_in_if                           mon_in,
    fa_out_if                          mon_out,
    output int                         o_fail_count,
    output int                         o_pending
);
    import fa_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  assigned_frame;
        logic [PAGE_W-1:0] page_out;
        logic              evicted;
        logic              frame_free;
        t_status           status;
    } t_frame_result;

    logic [NUM_FRAMES-1:0] free_bits;
    int unsigned           managed;
    logic [IDX_W-1:0]      lru_order[$];
    t_frame_result         result_due[$];
    t_frame_result         due_item;
    int                    fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic void reset_frames(logic [CFG_W-1:0] count);
        if (count < 1) managed = 1;
        else if (count > NUM_FRAMES) managed = NUM_FRAMES;
        else managed = count;
        free_bits = '1;
        lru_order.delete();
    endfunction

    function automatic void drop_from_order(logic [IDX_W-1:0] frame);
        for (int i = 0; i < lru_order.size(); i++) begin
            if (lru_order[i] == frame) begin
                lru_order.delete(i);
                return;
            end
        end
    endfunction

    function automatic t_frame_result predict_frame_result(t_op op, logic [IDX_W-1:0] idx,
                                                           logic [PAGE_W-1:0] page);
        t_frame_result    r;
        int               lowest;
        logic [IDX_W-1:0] victim;
        r.assigned_frame = idx;
        r.page_out       = page;
        r.evicted        = 1'b0;
        r.frame_free     = 1'b0;
        r.status         = ST_OK;
        if (op == OP_ALLOC) begin
            lowest = -1;
            for (int i = 0; i < managed; i++) begin
                if (lowest < 0 && free_bits[i]) lowest = i;
            end
            if (lowest >= 0) begin
                free_bits[lowest] = 1'b0;
                lru_order.insert(lru_order.size(), IDX_W'(lowest));
                r.assigned_frame = IDX_W'(lowest);
            end else if (lru_order.size() > 0) begin
                victim = lru_order[0];
                lru_order.delete(0);
                lru_order.insert(lru_order.size(), victim);
                r.assigned_frame = victim;
                r.evicted        = 1'b1;
            end else begin
                r.assigned_frame = '0;
                r.status         = ST_RANGE;
            end
        end else if (idx >= managed) begin
            r.status = ST_RANGE;
        end else if (op == OP_QUERY) begin
            r.frame_free = free_bits[idx];
        end else if (free_bits[idx]) begin
            r.status = ST_IS_FREE;
        end else if (op == OP_FREE) begin
            free_bits[idx] = 1'b1;
            drop_from_order(idx);
        end else begin
            drop_from_order(idx);
            lru_order.insert(lru_order.size(), idx);
        end
        return r;
    endfunction

    task automatic check_result(t_frame_result want);
        if (want.assigned_frame !== mon_out.assigned_frame) begin
            $error("assigned_frame mismatch: expected %0d, actual %0d",
                   want.assigned_frame, mon_out.assigned_frame);
            fail_total++;
        end
        if (want.page_out !== mon_out.page_out) begin
            $error("page_out mismatch: expected %0h, actual %0h", want.page_out, mon_out.page_out);
            fail_total++;
        end
        if (want.evicted !== mon_out.evicted) begin
            $error("evicted mismatch: expected %0d, actual %0d", want.evicted, mon_out.evicted);
            fail_total++;
        end
        if (want.frame_free !== mon_out.frame_free) begin
            $error("frame_free mismatch: expected %0d, actual %0d",
                   want.frame_free, mon_out.frame_free);
            fail_total++;
        end
        if (want.status !== mon_out.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, mon_out.status);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_frames(FRAMES_RESET);
            result_due.delete();
        end else begin
            if (mon_out.valid && mon_out.ready) begin
                if (result_due.size() == 0) begin
                    $error("result item with no request outstanding");
                    fail_total++;
                end else begin
                    due_item = result_due[0];
                    result_due.delete(0);
                    check_result(due_item);
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr[2] == REG_FRAMES_IN_USE)
                reset_frames(i_pwdata[CFG_W-1:0]);
            if (mon_in.valid && mon_in.ready)
                result_due.insert(result_due.size(),
                                  predict_frame_result(t_op'(mon_in.op), mon_in.frame_index,
                                                       mon_in.page_number));
        end
        o_pending <= result_due.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the frame allocator: a directed pass over exhaustion,
// eviction, touch, free and out-of-range requests, then random request
// streams under several frame counts, with random gaps, random result
// stalls and one long stall that backs up the request channel.
// ----------------------------------------------------------------------------
module tb;
    import fa_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 4000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned NUM_PHASES  = 8;
    localparam int          PHASE_FRAMES [NUM_PHASES] = '{1, 2, 8, 127, 0, 33, 64, 5};
    localparam int          PHASE_ITEMS  [NUM_PHASES] = '{100, 150, 350, 300, 80, 300, 300, 150};

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int          fail_count;
    int          pending;
    bit          gaps_on   = 1'b0;
    bit          stalls_on = 1'b0;
    bit          hold_req  = 1'b0;
    int unsigned managed   = NUM_FRAMES;
    int unsigned idle_cycles = 0;

    fa_in_if  req_ch ();
    fa_out_if rsp_ch ();

    frame_allocator_lru_evict dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (req_ch),
        .o_out   (rsp_ch)
    );

    fa_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .mon_in       (req_ch),
        .mon_out      (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_req(t_op op, logic [IDX_W-1:0] idx, logic [PAGE_W-1:0] page);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.frame_index <= idx;
        req_ch.page_number <= page;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // drop valid and let every outstanding result drain
    task automatic finish_phase();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_frames(logic [CFG_W-1:0] count);
        finish_phase();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata  <= {25'($urandom()), count};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (count < 1) managed = 1;
        else if (count > NUM_FRAMES) managed = NUM_FRAMES;
        else managed = count;
    endtask

    initial begin
        rsp_ch.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stalls_on && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                rsp_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int               pick;
        t_op              op;
        logic [IDX_W-1:0] idx;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_ALLOC;
        req_ch.frame_index = '0;
        req_ch.page_number = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        // reset frame count
        send_req(OP_ALLOC, 6'd17, 20'hFFFFF);
        send_req(OP_QUERY, 6'd63, 20'h00000);
        send_req(OP_QUERY, 6'd0, 20'h12345);

        // exhaustion and eviction with four frames
        write_frames(7'd4);
        send_req(OP_ALLOC, 6'd0, 20'h00000);
        send_req(OP_ALLOC, 6'd0, 20'hFFFFF);
        send_req(OP_ALLOC, 6'd0, 20'hAAAAA);
        send_req(OP_ALLOC, 6'd0, 20'h55555);
        send_req(OP_ALLOC, 6'd63, 20'hFFFFF);
        send_req(OP_TOUCH, 6'd1, 20'h00001);
        send_req(OP_ALLOC, 6'd0, 20'h80000);
        send_req(OP_FREE, 6'd3, 20'h00003);
        send_req(OP_QUERY, 6'd3, 20'h00004);
        send_req(OP_QUERY, 6'd0, 20'h00005);
        send_req(OP_TOUCH, 6'd3, 20'h00006);
        send_req(OP_FREE, 6'd3, 20'h00007);
        send_req(OP_QUERY, 6'd4, 20'hFFFFF);
        send_req(OP_FREE, 6'd63, 20'h00000);
        send_req(OP_TOUCH, 6'd5, 20'hAAAAA);
        send_req(OP_ALLOC, 6'd42, 20'h55555);
        send_req(OP_FREE, 6'd0, 20'h00008);
        send_req(OP_FREE, 6'd1, 20'h00009);
        send_req(OP_FREE, 6'd2, 20'h0000A);
        send_req(OP_FREE, 6'd3, 20'h0000B);
        send_req(OP_ALLOC, 6'd0, 20'h0000C);

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_frames(CFG_W'(PHASE_FRAMES[p]));
            if (p == 2) hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
                if (p == NUM_PHASES - 1) begin
                    gaps_on   = 1'b0;
                    stalls_on = 1'b0;
                end else begin
                    gaps_on   = (n % 128) < 96;
                    stalls_on = ((n + 40) % 128) < 100;
                end
                pick = $urandom_range(0, 99);
                if (pick < 40) op = OP_ALLOC;
                else if (pick < 60) op = OP_FREE;
                else if (pick < 75) op = OP_TOUCH;
                else op = OP_QUERY;
                if ($urandom_range(0, 9) < 8) idx = IDX_W'($urandom_range(0, managed - 1));
                else idx = IDX_W'($urandom_range(0, NUM_FRAMES - 1));
                send_req(op, idx, PAGE_W'($urandom()));
            end
        end

        finish_phase();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
